// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the checker file of the block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property check, disabled while reset is asserted
`define OWBM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: check failed");

// Check that also runs through reset
`define OWBM_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: check failed");

`endif

// ===== rtl/core/owbm_pkg.sv =====
// Package: widths, command codes, register indexes, default timings and result bit positions of the one-wire master
package owbm_pkg;

    localparam int unsigned BITS_PER_BYTE = 8;
    localparam int unsigned COUNT_W       = 11;
    localparam int unsigned BIT_IDX_W     = 3;
    localparam int unsigned CFG_IDX_W     = 3;
    localparam int unsigned CFG_DATA_W    = 10;
    localparam int unsigned S_TDATA_W     = 16;
    localparam int unsigned S_TUSER_W     = 2;
    localparam int unsigned M_TDATA_W     = 16;

    typedef enum logic [S_TUSER_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_RESET = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_READ  = 2'd3
    } command_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RESET_LOW       = 3'd0,
        REG_PRESENCE_SAMPLE = 3'd1,
        REG_RESET_RECOVERY  = 3'd2,
        REG_SLOT_LENGTH     = 3'd3,
        REG_WRITE_ONE_LOW   = 3'd4,
        REG_WRITE_ZERO_LOW  = 3'd5,
        REG_READ_LOW        = 3'd6,
        REG_READ_SAMPLE     = 3'd7
    } cfg_index_t;

    localparam logic [9:0] RESET_LOW_DEFAULT       = 10'd480;
    localparam logic [7:0] PRESENCE_SAMPLE_DEFAULT = 8'd70;
    localparam logic [9:0] RESET_RECOVERY_DEFAULT  = 10'd410;
    localparam logic [7:0] SLOT_LENGTH_DEFAULT     = 8'd70;
    localparam logic [7:0] WRITE_ONE_LOW_DEFAULT   = 8'd6;
    localparam logic [7:0] WRITE_ZERO_LOW_DEFAULT  = 8'd60;
    localparam logic [7:0] READ_LOW_DEFAULT        = 8'd6;
    localparam logic [7:0] READ_SAMPLE_DEFAULT     = 8'd15;

    // result bit positions in m_tdata
    localparam int unsigned M_DRIVE_LOW_BIT   = 0;
    localparam int unsigned M_BUSY_BIT        = 1;
    localparam int unsigned M_DONE_BIT        = 2;
    localparam int unsigned M_READ_BYTE_LSB   = 3;
    localparam int unsigned M_NO_PRESENCE_BIT = 11;
    localparam int unsigned M_REJECTED_BIT    = 12;

endpackage

// ===== rtl/core/one_wire_bus_master_core.sv =====
// Top level: one-wire bus master timing engine with stream ports and register write port
//
//  channel | direction | handshake          | contents
//  --------+-----------+--------------------+----------------------------------------------
//  s_      | in        | s_tvalid/s_tready  | tick or command, write byte, sampled line
//  m_      | out       | m_tvalid/m_tready  | drive, busy, done, read byte, presence, reject
//  cfg_    | in        | cfg_valid/cfg_ready| timing register index and value
//
//  One item per clock while s_tready is high: the phase, counter and shift registers
//  update in the cycle of the transfer and the result is registered once.
//  An output register plus one skid entry keep s_tready high while one result waits.
//  Reset (aresetn low, synchronous) restores idle state and the default timings.
//  cfg_ready is always high.
module one_wire_bus_master_core
    import owbm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [7:0] data_byte, [8] line_in, [15:9] zero
    input  logic [S_TUSER_W-1:0]  s_tuser,   // [1:0] command
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [0] drive_low, [1] busy_res, [2] done_res,
                                             // [10:3] read_byte, [11] no_presence,
                                             // [12] rejected, [15:13] zero
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_RESET = 2'd1,
        PH_WRITE = 2'd2,
        PH_READ  = 2'd3
    } phase_t;

    localparam logic [BIT_IDX_W-1:0] LAST_BIT = BIT_IDX_W'(BITS_PER_BYTE - 1);
    localparam logic [BIT_IDX_W-1:0] SEG_LOW      = 3'd0;
    localparam logic [BIT_IDX_W-1:0] SEG_PRESENCE = 3'd1;
    localparam logic [BIT_IDX_W-1:0] SEG_RECOVERY = 3'd2;

    logic [9:0] reset_low_reg, reset_recovery_reg;
    logic [7:0] presence_sample_reg, slot_length_reg, write_one_low_reg;
    logic [7:0] write_zero_low_reg, read_low_reg, read_sample_reg;

    phase_t                     phase_reg, phase_next;
    logic [COUNT_W-1:0]         count_reg, count_next, count_inc;
    logic [BIT_IDX_W-1:0]       bit_index_reg, bit_index_next;
    logic [BITS_PER_BYTE-1:0]   shift_reg, shift_next;
    logic                       presence_reg, presence_next;
    logic [BITS_PER_BYTE-1:0]   last_read_reg, last_read_next;

    logic                       accept;
    command_t                   cmd;
    logic [BITS_PER_BYTE-1:0]   in_byte;
    logic                       in_line;
    logic                       done, rejected, drive_low;
    logic [COUNT_W-1:0]         low_time, slot_len, read_sample;
    logic                       sample_inside;
    logic [M_TDATA_W-1:0]       result;

    logic                       out_valid_reg, skid_valid_reg;
    logic [M_TDATA_W-1:0]       out_data_reg, skid_data_reg;

    assign accept    = s_tvalid && s_tready;
    assign cmd       = command_t'(s_tuser);
    assign in_byte   = s_tdata[BITS_PER_BYTE-1:0];
    assign in_line   = s_tdata[BITS_PER_BYTE];
    assign cfg_ready = 1'b1;
    assign s_tready  = !skid_valid_reg;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    assign count_inc     = count_reg + 1'b1;
    assign slot_len      = COUNT_W'(slot_length_reg);
    assign read_sample   = COUNT_W'(read_sample_reg);
    assign sample_inside = read_sample_reg < slot_length_reg;

    always_comb begin
        phase_next     = phase_reg;
        count_next     = count_reg;
        bit_index_next = bit_index_reg;
        shift_next     = shift_reg;
        presence_next  = presence_reg;
        last_read_next = last_read_reg;
        done           = 1'b0;
        rejected       = 1'b0;
        if (cmd == CMD_TICK) begin
            if (phase_reg == PH_RESET) begin
                count_next = count_inc;
                if (bit_index_reg == SEG_LOW) begin
                    if (count_inc >= COUNT_W'(reset_low_reg)) begin
                        bit_index_next = SEG_PRESENCE;
                        count_next     = '0;
                    end
                end else if (bit_index_reg == SEG_PRESENCE) begin
                    if (count_inc >= COUNT_W'(presence_sample_reg)) begin
                        presence_next  = in_line;
                        bit_index_next = SEG_RECOVERY;
                        count_next     = '0;
                    end
                end else if (count_inc >= COUNT_W'(reset_recovery_reg)) begin
                    phase_next     = PH_IDLE;
                    bit_index_next = '0;
                    count_next     = '0;
                    done           = 1'b1;
                end
            end else if (phase_reg != PH_IDLE) begin
                count_next = count_inc;
                if (phase_reg == PH_READ && count_inc == read_sample && sample_inside) begin
                    shift_next = {in_line, shift_reg[BITS_PER_BYTE-1:1]};
                end
                if (count_inc >= slot_len) begin
                    if (phase_reg == PH_READ) begin
                        if (!sample_inside) begin
                            shift_next = {in_line, shift_reg[BITS_PER_BYTE-1:1]};
                        end
                    end else begin
                        shift_next = {1'b0, shift_reg[BITS_PER_BYTE-1:1]};
                    end
                    count_next = '0;
                    if (bit_index_reg == LAST_BIT) begin
                        if (phase_reg == PH_READ) begin
                            last_read_next = shift_next;
                        end
                        phase_next     = PH_IDLE;
                        bit_index_next = '0;
                        done           = 1'b1;
                    end else begin
                        bit_index_next = bit_index_reg + 1'b1;
                    end
                end
            end
        end else if (phase_reg != PH_IDLE) begin
            rejected = 1'b1;
        end else begin
            count_next     = '0;
            bit_index_next = '0;
            unique case (cmd)
                CMD_RESET: phase_next = PH_RESET;
                CMD_WRITE: begin
                    phase_next = PH_WRITE;
                    shift_next = in_byte;
                end
                default: begin
                    phase_next = PH_READ;
                    shift_next = '0;
                end
            endcase
        end
    end

    always_comb begin
        unique case (phase_next)
            PH_WRITE: low_time = COUNT_W'(shift_next[0] ? write_one_low_reg : write_zero_low_reg);
            PH_READ:  low_time = COUNT_W'(read_low_reg);
            PH_RESET: low_time = COUNT_W'(reset_low_reg);
            default:  low_time = '0;
        endcase
        if (phase_next == PH_IDLE) begin
            drive_low = 1'b0;
        end else if (phase_next == PH_RESET && bit_index_next != SEG_LOW) begin
            drive_low = 1'b0;
        end else begin
            drive_low = count_next < low_time;
        end
    end

    assign result = {3'b000, rejected, presence_next, last_read_next, done,
                     (phase_next != PH_IDLE), drive_low};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reset_low_reg       <= RESET_LOW_DEFAULT;
            presence_sample_reg <= PRESENCE_SAMPLE_DEFAULT;
            reset_recovery_reg  <= RESET_RECOVERY_DEFAULT;
            slot_length_reg     <= SLOT_LENGTH_DEFAULT;
            write_one_low_reg   <= WRITE_ONE_LOW_DEFAULT;
            write_zero_low_reg  <= WRITE_ZERO_LOW_DEFAULT;
            read_low_reg        <= READ_LOW_DEFAULT;
            read_sample_reg     <= READ_SAMPLE_DEFAULT;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index_t'(cfg_index))
                REG_RESET_LOW:       reset_low_reg       <= cfg_data;
                REG_PRESENCE_SAMPLE: presence_sample_reg <= cfg_data[7:0];
                REG_RESET_RECOVERY:  reset_recovery_reg  <= cfg_data;
                REG_SLOT_LENGTH:     slot_length_reg     <= cfg_data[7:0];
                REG_WRITE_ONE_LOW:   write_one_low_reg   <= cfg_data[7:0];
                REG_WRITE_ZERO_LOW:  write_zero_low_reg  <= cfg_data[7:0];
                REG_READ_LOW:        read_low_reg        <= cfg_data[7:0];
                default:             read_sample_reg     <= cfg_data[7:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            count_reg     <= '0;
            bit_index_reg <= '0;
            shift_reg     <= '0;
            presence_reg  <= 1'b0;
            last_read_reg <= '0;
        end else if (accept) begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            bit_index_reg <= bit_index_next;
            shift_reg     <= shift_next;
            presence_reg  <= presence_next;
            last_read_reg <= last_read_next;
        end
    end

    // output register with one skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_tready || !out_valid_reg) begin
            out_valid_reg  <= skid_valid_reg || accept;
            skid_valid_reg <= 1'b0;
        end else if (accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_tready || !out_valid_reg) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : result;
        end else if (accept) begin
            skid_data_reg <= result;
        end
    end

endmodule

// ===== rtl/core/owbm_checker.sv =====
// Checker: port-level properties of the one-wire master, bound to the top level
`include "assert_macros.svh"

module owbm_checker
    import owbm_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    `OWBM_ASSERT(a_reject_only_when_busy, aclk, aresetn, m_tvalid && m_tdata[M_REJECTED_BIT] |-> m_tdata[M_BUSY_BIT])

    `OWBM_ASSERT(a_done_leaves_idle, aclk, aresetn, m_tvalid && m_tdata[M_DONE_BIT] |-> !m_tdata[M_BUSY_BIT] && !m_tdata[M_DRIVE_LOW_BIT])

    `OWBM_ASSERT(a_drive_only_when_busy, aclk, aresetn, m_tvalid && m_tdata[M_DRIVE_LOW_BIT] |-> m_tdata[M_BUSY_BIT])

    `OWBM_ASSERT(a_stalled_result_holds, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

    `OWBM_ASSERT_ALWAYS(a_reset_clears_output, aclk, !aresetn |=> !m_tvalid && s_tready)

endmodule

bind one_wire_bus_master_core owbm_checker u_owbm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== test/one_wire_bus_master_core_test.sv =====
// Testbench: one-wire master core driven by directed and random transfers, checked by a predictor
`timescale 1ns / 1ps

module one_wire_bus_master_core_test;
    import owbm_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_RESET = 2'd1,
        PH_WRITE = 2'd2,
        PH_READ  = 2'd3
    } bus_phase_e;

    typedef enum int {
        PLAN_DEFAULT,
        PLAN_SMALL,
        PLAN_MAX,
        PLAN_MIN,
        PLAN_ZERO,
        PLAN_LONG_LOW
    } plan_style_e;

    typedef struct packed {
        logic       drive_low;
        logic       busy;
        logic       done;
        logic [7:0] read_byte;
        logic       no_presence;
        logic       rejected;
    } bus_result_t;

    typedef struct packed {
        command_t    cmd;
        logic [7:0]  data;
        logic        line;
        logic        pinned;
        bus_result_t want;
    } stim_row_t;

    localparam logic [BIT_IDX_W-1:0] SEG_LOW      = 3'd0;
    localparam logic [BIT_IDX_W-1:0] SEG_PRESENCE = 3'd1;
    localparam logic [BIT_IDX_W-1:0] SEG_RECOVERY = 3'd2;
    localparam int NUM_PHASES = 10;
    localparam int HOLD_CYCLES = 300;
    localparam bus_result_t FREE = '0;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [S_TUSER_W-1:0]  s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // predictor state
    bus_phase_e           ph;
    logic [COUNT_W-1:0]   us_count;
    logic [BIT_IDX_W-1:0] slot_bit;
    logic [7:0]           shreg;
    logic                 presence;
    logic [7:0]           last_rd;
    logic [9:0]           tm [8];

    bus_result_t bus_outcomes [$];
    stim_row_t   script [$];
    int unsigned faults = 0;

    // stimulus side
    int unsigned cfg_now [8];
    logic [9:0]  plan [8];
    int unsigned busy_left  = 0;
    int unsigned items_done = 0;
    int unsigned tx_gap_pct = 0;
    int unsigned rx_stall_pct = 0;
    logic        hold_request = 1'b0;
    int unsigned hold_left  = 0;
    logic        row_pinned = 1'b0;
    bus_result_t row_want   = '0;

    plan_style_e phase_styles [NUM_PHASES] = '{PLAN_DEFAULT, PLAN_SMALL, PLAN_SMALL, PLAN_SMALL,
        PLAN_MAX, PLAN_SMALL, PLAN_MIN, PLAN_LONG_LOW, PLAN_ZERO, PLAN_SMALL};

    one_wire_bus_master_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // [7:0] data_byte, [8] line_in, [15:9] zero
        .s_tuser   (s_tuser),    // [1:0] command
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // [0] drive_low, [1] busy_res, [2] done_res,
                                 // [10:3] read_byte, [11] no_presence, [12] rejected
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    initial begin
        #2000000;
        $display("FAIL one_wire_bus_master_core");
        $finish;
    end

    function automatic void reset_bus();
        ph       = PH_IDLE;
        us_count = '0;
        slot_bit = '0;
        shreg    = '0;
        presence = 1'b0;
        last_rd  = '0;
        tm[REG_RESET_LOW]       = RESET_LOW_DEFAULT;
        tm[REG_PRESENCE_SAMPLE] = {2'b00, PRESENCE_SAMPLE_DEFAULT};
        tm[REG_RESET_RECOVERY]  = RESET_RECOVERY_DEFAULT;
        tm[REG_SLOT_LENGTH]     = {2'b00, SLOT_LENGTH_DEFAULT};
        tm[REG_WRITE_ONE_LOW]   = {2'b00, WRITE_ONE_LOW_DEFAULT};
        tm[REG_WRITE_ZERO_LOW]  = {2'b00, WRITE_ZERO_LOW_DEFAULT};
        tm[REG_READ_LOW]        = {2'b00, READ_LOW_DEFAULT};
        tm[REG_READ_SAMPLE]     = {2'b00, READ_SAMPLE_DEFAULT};
    endfunction

    function automatic void store_timing(cfg_index_t idx, logic [9:0] value);
        if (idx == REG_RESET_LOW || idx == REG_RESET_RECOVERY)
            tm[idx] = value;
        else
            tm[idx] = {2'b00, value[7:0]};
    endfunction

    function automatic logic line_low();
        logic [9:0] low;
        case (ph)
            PH_RESET: return (slot_bit == SEG_LOW) && (us_count < tm[REG_RESET_LOW]);
            PH_WRITE: low = shreg[0] ? tm[REG_WRITE_ONE_LOW] : tm[REG_WRITE_ZERO_LOW];
            PH_READ:  low = tm[REG_READ_LOW];
            default:  return 1'b0;
        endcase
        return us_count < low;
    endfunction

    function automatic logic tick_bus(logic line);
        if (ph == PH_IDLE)
            return 1'b0;
        us_count = us_count + 1'b1;
        if (ph == PH_RESET) begin
            if (slot_bit == SEG_LOW) begin
                if (us_count >= tm[REG_RESET_LOW]) begin
                    slot_bit = SEG_PRESENCE;
                    us_count = '0;
                end
            end else if (slot_bit == SEG_PRESENCE) begin
                if (us_count >= tm[REG_PRESENCE_SAMPLE]) begin
                    presence = line;
                    slot_bit = SEG_RECOVERY;
                    us_count = '0;
                end
            end else if (us_count >= tm[REG_RESET_RECOVERY]) begin
                ph       = PH_IDLE;
                slot_bit = '0;
                us_count = '0;
                return 1'b1;
            end
            return 1'b0;
        end
        if (ph == PH_READ && us_count == tm[REG_READ_SAMPLE] &&
            tm[REG_READ_SAMPLE] < tm[REG_SLOT_LENGTH])
            shreg = {line, shreg[7:1]};
        if (us_count >= tm[REG_SLOT_LENGTH]) begin
            if (ph == PH_READ) begin
                if (tm[REG_READ_SAMPLE] >= tm[REG_SLOT_LENGTH])
                    shreg = {line, shreg[7:1]};
            end else begin
                shreg = shreg >> 1;
            end
            us_count = '0;
            if (int'(slot_bit) == BITS_PER_BYTE - 1) begin
                if (ph == PH_READ)
                    last_rd = shreg;
                ph       = PH_IDLE;
                slot_bit = '0;
                return 1'b1;
            end
            slot_bit = slot_bit + 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bus_result_t advance_bus(command_t cmd, logic [7:0] data, logic line);
        bus_result_t r;
        r = '0;
        if (cmd == CMD_TICK) begin
            r.done = tick_bus(line);
        end else if (ph != PH_IDLE) begin
            r.rejected = 1'b1;
        end else begin
            us_count = '0;
            slot_bit = '0;
            case (cmd)
                CMD_RESET: ph = PH_RESET;
                CMD_WRITE: begin
                    ph    = PH_WRITE;
                    shreg = data;
                end
                default: begin
                    ph    = PH_READ;
                    shreg = '0;
                end
            endcase
        end
        r.drive_low   = line_low();
        r.busy        = (ph != PH_IDLE);
        r.read_byte   = last_rd;
        r.no_presence = presence;
        return r;
    endfunction

    function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            faults++;
        end
    endfunction

    always @(posedge aclk) begin : monitor
        bus_result_t want, got;
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                store_timing(cfg_index_t'(cfg_index), cfg_data);
            if (m_tvalid && m_tready) begin
                if (bus_outcomes.size() == 0) begin
                    $error("m_tdata: expected no transfer, got %h", m_tdata);
                    faults++;
                end else begin
                    want = bus_outcomes.pop_front();
                    compare_field("drive_low", want.drive_low, m_tdata[M_DRIVE_LOW_BIT]);
                    compare_field("busy_res", want.busy, m_tdata[M_BUSY_BIT]);
                    compare_field("done_res", want.done, m_tdata[M_DONE_BIT]);
                    compare_field("read_byte", want.read_byte,
                                  m_tdata[M_READ_BYTE_LSB +: 8]);
                    compare_field("no_presence", want.no_presence, m_tdata[M_NO_PRESENCE_BIT]);
                    compare_field("rejected", want.rejected, m_tdata[M_REJECTED_BIT]);
                end
            end
            if (s_tvalid && s_tready) begin
                got = advance_bus(command_t'(s_tuser), s_tdata[7:0], s_tdata[8]);
                bus_outcomes.push_back(row_pinned ? row_want : got);
            end
        end
    end

    always @(negedge aclk) begin
        if (hold_request && hold_left == 0) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    function automatic int unsigned span_of(command_t cmd);
        if (cmd == CMD_RESET)
            return (cfg_now[REG_RESET_LOW] == 0 ? 1 : cfg_now[REG_RESET_LOW]) +
                   (cfg_now[REG_PRESENCE_SAMPLE] == 0 ? 1 : cfg_now[REG_PRESENCE_SAMPLE]) +
                   (cfg_now[REG_RESET_RECOVERY] == 0 ? 1 : cfg_now[REG_RESET_RECOVERY]);
        return BITS_PER_BYTE * (cfg_now[REG_SLOT_LENGTH] == 0 ? 1 : cfg_now[REG_SLOT_LENGTH]);
    endfunction

    task automatic offer(command_t cmd, logic [7:0] data, logic line, logic pinned,
                         bus_result_t want);
        @(negedge aclk);
        while ($urandom_range(0, 99) < tx_gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid   <= 1'b1;
        s_tuser    <= cmd;
        s_tdata    <= {7'b0, line, data};
        row_pinned = pinned;
        row_want   = want;
        do @(posedge aclk); while (!s_tready);
        if (cmd == CMD_TICK) begin
            if (busy_left != 0) begin
                busy_left--;
                items_done++;
            end
        end else begin
            if (busy_left == 0)
                busy_left = span_of(cmd);
            items_done++;
        end
    endtask

    task automatic offer_tick();
        offer(CMD_TICK, 8'($urandom), 1'($urandom), 1'b0, FREE);
    endtask

    task automatic finish_busy();
        while (busy_left != 0)
            offer_tick();
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (bus_outcomes.size() != 0)
            @(posedge aclk);
    endtask

    task automatic add_row(command_t cmd, logic [7:0] data, logic line, logic pinned,
                           bus_result_t want);
        stim_row_t row;
        row.cmd    = cmd;
        row.data   = data;
        row.line   = line;
        row.pinned = pinned;
        row.want   = want;
        script.push_back(row);
    endtask

    task automatic run_script();
        stim_row_t row;
        while (script.size() != 0) begin
            row = script.pop_front();
            offer(row.cmd, row.data, row.line, row.pinned, row.want);
        end
    endtask

    function automatic bus_result_t pin(logic dl, logic bsy, logic dn, logic [7:0] rb,
                                        logic np, logic rej);
        bus_result_t r;
        r.drive_low   = dl;
        r.busy        = bsy;
        r.done        = dn;
        r.read_byte   = rb;
        r.no_presence = np;
        r.rejected    = rej;
        return r;
    endfunction

    task automatic pick_plan(plan_style_e style);
        int unsigned slot;
        case (style)
            PLAN_DEFAULT: begin
                plan[REG_RESET_LOW]       = RESET_LOW_DEFAULT;
                plan[REG_PRESENCE_SAMPLE] = {2'b00, PRESENCE_SAMPLE_DEFAULT};
                plan[REG_RESET_RECOVERY]  = RESET_RECOVERY_DEFAULT;
                plan[REG_SLOT_LENGTH]     = {2'b00, SLOT_LENGTH_DEFAULT};
                plan[REG_WRITE_ONE_LOW]   = {2'b00, WRITE_ONE_LOW_DEFAULT};
                plan[REG_WRITE_ZERO_LOW]  = {2'b00, WRITE_ZERO_LOW_DEFAULT};
                plan[REG_READ_LOW]        = {2'b00, READ_LOW_DEFAULT};
                plan[REG_READ_SAMPLE]     = {2'b00, READ_SAMPLE_DEFAULT};
            end
            PLAN_MAX: begin
                for (int i = 0; i < 8; i++)
                    plan[i] = 10'd255;
                plan[REG_RESET_LOW]      = 10'd1023;
                plan[REG_RESET_RECOVERY] = 10'd1023;
            end
            PLAN_MIN: begin
                for (int i = 0; i < 8; i++)
                    plan[i] = 10'd1;
            end
            PLAN_ZERO: begin
                for (int i = 0; i < 8; i++)
                    plan[i] = 10'd0;
            end
            PLAN_LONG_LOW: begin
                slot = $urandom_range(1, 6);
                plan[REG_RESET_LOW]       = 10'($urandom_range(1, 10));
                plan[REG_PRESENCE_SAMPLE] = 10'($urandom_range(1, 6));
                plan[REG_RESET_RECOVERY]  = 10'($urandom_range(1, 10));
                plan[REG_SLOT_LENGTH]     = 10'(slot);
                plan[REG_WRITE_ONE_LOW]   = 10'($urandom_range(10, 255));
                plan[REG_WRITE_ZERO_LOW]  = 10'($urandom_range(10, 255));
                plan[REG_READ_LOW]        = 10'($urandom_range(10, 255));
                plan[REG_READ_SAMPLE]     = 10'($urandom_range(0, 255));
            end
            default: begin
                slot = $urandom_range(1, 16);
                plan[REG_RESET_LOW]       = 10'($urandom_range(1, 12));
                plan[REG_PRESENCE_SAMPLE] = 10'($urandom_range(1, 8));
                plan[REG_RESET_RECOVERY]  = 10'($urandom_range(1, 12));
                plan[REG_SLOT_LENGTH]     = 10'(slot);
                plan[REG_WRITE_ONE_LOW]   = 10'($urandom_range(0, slot + 2));
                plan[REG_WRITE_ZERO_LOW]  = 10'($urandom_range(0, slot + 2));
                plan[REG_READ_LOW]        = 10'($urandom_range(0, slot + 2));
                plan[REG_READ_SAMPLE]     = 10'($urandom_range(0, slot + 3));
            end
        endcase
    endtask

    task automatic apply_plan();
        logic [1:0] junk;
        logic       wide;
        for (int i = 0; i < 8; i++) begin
            junk = 2'($urandom);
            wide = (i == REG_RESET_LOW) || (i == REG_RESET_RECOVERY);
            @(negedge aclk);
            cfg_valid  <= 1'b1;
            cfg_index  <= cfg_index_t'(i);
            cfg_data   <= wide ? plan[i] : {junk, plan[i][7:0]};
            cfg_now[i] = wide ? plan[i] : plan[i][7:0];
            do @(posedge aclk); while (!cfg_ready);
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic offer_command();
        offer(command_t'($urandom_range(1, 3)), 8'($urandom), 1'($urandom), 1'b0, FREE);
    endtask

    task automatic run_sequence();
        finish_busy();
        offer_command();
        while (busy_left != 0) begin
            if ($urandom_range(0, 19) == 0)
                offer_command();
            offer_tick();
        end
    endtask

    task automatic run_broken();
        int unsigned cut;
        finish_busy();
        offer_command();
        cut = $urandom_range(0, busy_left);
        repeat (cut) offer_tick();
        offer_command();
    endtask

    task automatic run_noise();
        repeat ($urandom_range(1, 3))
            offer(command_t'($urandom_range(0, 3)), 8'($urandom), 1'($urandom), 1'b0, FREE);
    endtask

    task automatic set_idling(int unsigned mode);
        case (mode)
            0: begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_gap_pct = 66; rx_stall_pct = 0;  end
            2: begin tx_gap_pct = 0;  rx_stall_pct = 66; end
            default: begin tx_gap_pct = 26; rx_stall_pct = 26; end
        endcase
    endtask

    initial begin : stimulus
        logic [7:0]  read_bits;
        int unsigned start, budget, pick;
        logic        pressed;
        reset_bus();
        for (int i = 0; i < 8; i++)
            cfg_now[i] = tm[i];
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        set_idling(3);
        add_row(CMD_TICK,  8'h00, 1'b0, 1'b1, pin(0, 0, 0, 8'h00, 0, 0));
        add_row(CMD_WRITE, 8'hFF, 1'b1, 1'b1, pin(1, 1, 0, 8'h00, 0, 0));
        add_row(CMD_READ,  8'h00, 1'b0, 1'b1, pin(1, 1, 0, 8'h00, 0, 1));
        add_row(CMD_RESET, 8'h5A, 1'b1, 1'b1, pin(1, 1, 0, 8'h00, 0, 1));
        run_script();
        finish_busy();
        drain();

        // every timing at zero: each condition met on the first tick
        pick_plan(PLAN_ZERO);
        apply_plan();
        add_row(CMD_RESET, 8'hC3, 1'b1, 1'b0, FREE);
        add_row(CMD_TICK,  8'h00, 1'b0, 1'b0, FREE);
        add_row(CMD_TICK,  8'hFF, 1'b1, 1'b0, FREE);
        add_row(CMD_TICK,  8'h00, 1'b0, 1'b0, FREE);
        add_row(CMD_WRITE, 8'hA5, 1'b0, 1'b0, FREE);
        for (int i = 0; i < BITS_PER_BYTE; i++)
            add_row(CMD_TICK, 8'(i * 37), 1'(i), 1'b0, FREE);
        add_row(CMD_READ, 8'h3C, 1'b1, 1'b0, FREE);
        read_bits = 8'h4D;
        for (int i = 0; i < BITS_PER_BYTE - 1; i++)
            add_row(CMD_TICK, 8'h00, read_bits[i], 1'b0, FREE);
        add_row(CMD_TICK, 8'h00, read_bits[7], 1'b1, pin(0, 0, 1, 8'h4D, 1, 0));
        run_script();

        for (int p = 0; p < NUM_PHASES; p++) begin
            finish_busy();
            drain();
            pick_plan(phase_styles[p]);
            apply_plan();
            set_idling(p % 4);
            budget  = (phase_styles[p] == PLAN_DEFAULT || phase_styles[p] == PLAN_MAX) ? 1 : 100;
            start   = items_done;
            pressed = 1'b0;
            while (items_done - start < budget) begin
                if (!pressed && items_done - start >= budget / 2) begin
                    pressed = 1'b1;
                    if (p == 2)
                        hold_request = 1'b1;
                    else if (p == 3)
                        drain();
                end
                pick = $urandom_range(0, 99);
                if (pick < 75)
                    run_sequence();
                else if (pick < 90)
                    run_broken();
                else
                    run_noise();
            end
        end

        finish_busy();
        drain();
        repeat (4) @(posedge aclk);
        if (faults == 0 && bus_outcomes.size() == 0)
            $display("PASS one_wire_bus_master_core");
        else
            $display("FAIL one_wire_bus_master_core");
        $finish;
    end

endmodule
